[design/slpc_pkg.sv]
// ----------------------------------------------------------------------------
// slpc_pkg: shared types and constants of the status LED pattern controller
// Event and pattern codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package slpc_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned PATTERN_W = 3;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_SET       = 3'd1,
    MODE_FORCE_ON  = 3'd2,
    MODE_FORCE_OFF = 3'd3,
    MODE_RELEASE   = 3'd4,
    MODE_FLASH     = 3'd5
  } mode_e;

  typedef enum logic [PATTERN_W-1:0] {
    PAT_OFF    = 3'd0,
    PAT_SOLID  = 3'd1,
    PAT_SLOW   = 3'd2,
    PAT_FAST   = 3'd3,
    PAT_DOUBLE = 3'd4,
    PAT_ALT    = 3'd5
  } pattern_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED      = 3'd0,
    REG_ACTIVE_HIGH  = 3'd1,
    REG_SLOW_HALF    = 3'd2,
    REG_FAST_HALF    = 3'd3,
    REG_DOUBLE_ON    = 3'd4,
    REG_DOUBLE_GAP   = 3'd5,
    REG_DOUBLE_PAUSE = 3'd6,
    REG_ALTERNATE    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_PULSE1 = 2'd0,
    PH_GAP    = 2'd1,
    PH_PULSE2 = 2'd2,
    PH_PAUSE  = 2'd3
  } dbl_phase_e;

  localparam logic [CFG_W-1:0] RST_SLOW_HALF    = 16'd500;
  localparam logic [CFG_W-1:0] RST_FAST_HALF    = 16'd62;
  localparam logic [CFG_W-1:0] RST_DOUBLE_ON    = 16'd100;
  localparam logic [CFG_W-1:0] RST_DOUBLE_GAP   = 16'd100;
  localparam logic [CFG_W-1:0] RST_DOUBLE_PAUSE = 16'd700;
  localparam logic [CFG_W-1:0] RST_ALTERNATE    = 16'd500;

endpackage

[design/slpc_evt_if.sv]
// ----------------------------------------------------------------------------
// slpc_evt_if: event channel of the status LED pattern controller
// One word is one event: mode, pattern code and flash duration.
// ----------------------------------------------------------------------------
interface slpc_evt_if;
  import slpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [PATTERN_W-1:0] pattern;
  logic [DUR_W-1:0]     flash_ms;

  modport source (output valid, output mode, output pattern, output flash_ms, input ready);
  modport sink   (input valid, input mode, input pattern, input flash_ms, output ready);
endinterface

[design/slpc_res_if.sv]
// ----------------------------------------------------------------------------
// slpc_res_if: result channel of the status LED pattern controller
// One word is the LED state and the pin level after one event.
// ----------------------------------------------------------------------------
interface slpc_res_if;
  logic valid;
  logic ready;
  logic led_on;
  logic pin_level;

  modport source (output valid, output led_on, output pin_level, input ready);
  modport sink   (input valid, input led_on, input pin_level, output ready);
endinterface

[design/status_led_pattern_controller_core.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_controller_core: status LED pattern controller
// Event-driven blink pattern generator with force, flash and pin polarity.
// ----------------------------------------------------------------------------
// Takes one event word per clock and returns exactly one result word per
// event, in the cycle after acceptance. Events are millisecond ticks, pattern
// changes (off, solid, slow, fast, double blink, alternating), force on/off,
// release and timed flash. All the work of an event is done in combinational
// logic between the state registers and the result register;
// the evt channel stays ready while the result register is empty or being
// drained, so a full stream of one event per clock is sustained as long as
// the result side takes a word every clock. Elapsed time and the flash
// countdown are TIME_BITS wide and saturate. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while
// no result is pending.
// ----------------------------------------------------------------------------
module status_led_pattern_controller_core #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [slpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [slpc_pkg::CFG_W-1:0]     cfg_wdata_i,
  slpc_evt_if.sink                      evt_i,
  slpc_res_if.source                    res_o
);
  import slpc_pkg::*;

  // Compare width: wide enough for both the time counters and 16-bit intervals.
  localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Configuration registers
  logic             enabled_q, active_high_q;
  logic [CFG_W-1:0] slow_half_q, fast_half_q, dbl_on_q, dbl_gap_q, dbl_pause_q, alt_q;

  // Controller state
  pattern_e             pattern_q, pattern_d;
  logic                 lit_q, lit_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  dbl_phase_e           phase_q, phase_d;
  logic                 force_q, force_d;
  logic                 force_lvl_q, force_lvl_d;
  logic                 timed_q, timed_d;
  logic [TIME_BITS-1:0] left_q, left_d;

  // Result register
  logic res_valid_q, res_led_q, res_pin_q;

  logic                 evt_fire;
  mode_e                mode;
  logic [TIME_BITS-1:0] elapsed_inc, left_dec;
  logic                 release_now;
  logic [CFG_W-1:0]     interval;
  logic                 step_due;
  logic [CMP_W-1:0]     dur_ext;

  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign evt_fire    = evt_i.valid && evt_i.ready;
  assign mode        = mode_e'(evt_i.mode);

  // Saturating time advance and flash countdown.
  assign elapsed_inc = (elapsed_q != TIME_MAX) ? elapsed_q + 1'b1 : elapsed_q;
  assign left_dec    = (timed_q && left_q != '0) ? left_q - 1'b1 : left_q;
  assign release_now = force_q && timed_q && (left_dec == '0);

  // Interval of the pattern step that is running now.
  always_comb begin
    case (pattern_q)
      PAT_SLOW: interval = slow_half_q;
      PAT_FAST: interval = fast_half_q;
      PAT_ALT:  interval = alt_q;
      PAT_DOUBLE: begin
        case (phase_q)
          PH_GAP:   interval = dbl_gap_q;
          PH_PAUSE: interval = dbl_pause_q;
          default:  interval = dbl_on_q;
        endcase
      end
      default:  interval = '0;
    endcase
  end

  assign step_due = CMP_W'(elapsed_inc) >= CMP_W'(interval);
  assign dur_ext  = CMP_W'(evt_i.flash_ms);

  always_comb begin
    pattern_d   = pattern_q;
    lit_d       = lit_q;
    elapsed_d   = elapsed_q;
    phase_d     = phase_q;
    force_d     = force_q;
    force_lvl_d = force_lvl_q;
    timed_d     = timed_q;
    left_d      = left_q;
    case (mode)
      MODE_TICK: begin
        elapsed_d = elapsed_inc;
        left_d    = left_dec;
        if (enabled_q) begin
          if (release_now) begin
            force_d = 1'b0;
            timed_d = 1'b0;
            left_d  = '0;
          end
          if (force_q && !release_now) begin
            lit_d = force_lvl_q;
          end else begin
            case (pattern_q)
              PAT_OFF:   lit_d = 1'b0;
              PAT_SOLID: lit_d = 1'b1;
              PAT_SLOW, PAT_FAST, PAT_ALT: begin
                if (step_due) begin
                  elapsed_d = '0;
                  lit_d     = !lit_q;
                end
              end
              PAT_DOUBLE: begin
                // Pulses are lit, gap and pause are dark.
                lit_d = (phase_q == PH_PULSE1) || (phase_q == PH_PULSE2);
                if (step_due) begin
                  elapsed_d = '0;
                  phase_d   = dbl_phase_e'(phase_q + 2'd1);
                end
              end
              default: ;
            endcase
          end
        end
      end
      MODE_SET: begin
        if (evt_i.pattern <= PAT_ALT && evt_i.pattern != pattern_q) begin
          pattern_d = pattern_e'(evt_i.pattern);
          elapsed_d = '0;
          phase_d   = PH_PULSE1;
          force_d   = 1'b0;
          timed_d   = 1'b0;
          left_d    = '0;
          lit_d     = (evt_i.pattern != PAT_OFF);
        end
      end
      MODE_FORCE_ON, MODE_FORCE_OFF: begin
        force_d     = 1'b1;
        force_lvl_d = (mode == MODE_FORCE_ON);
        timed_d     = 1'b0;
        left_d      = '0;
        lit_d       = (mode == MODE_FORCE_ON);
      end
      MODE_RELEASE: begin
        force_d = 1'b0;
        timed_d = 1'b0;
        left_d  = '0;
      end
      MODE_FLASH: begin
        force_d     = 1'b1;
        force_lvl_d = 1'b1;
        timed_d     = 1'b1;
        // Clamp the duration to the counter range.
        left_d      = (dur_ext > CMP_W'(TIME_MAX)) ? TIME_MAX : dur_ext[TIME_BITS-1:0];
        lit_d       = 1'b1;
      end
      default: ;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q     <= 1'b1;
      active_high_q <= 1'b1;
      slow_half_q   <= RST_SLOW_HALF;
      fast_half_q   <= RST_FAST_HALF;
      dbl_on_q      <= RST_DOUBLE_ON;
      dbl_gap_q     <= RST_DOUBLE_GAP;
      dbl_pause_q   <= RST_DOUBLE_PAUSE;
      alt_q         <= RST_ALTERNATE;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLED:      enabled_q     <= cfg_wdata_i[0];
        REG_ACTIVE_HIGH:  active_high_q <= cfg_wdata_i[0];
        REG_SLOW_HALF:    slow_half_q   <= cfg_wdata_i;
        REG_FAST_HALF:    fast_half_q   <= cfg_wdata_i;
        REG_DOUBLE_ON:    dbl_on_q      <= cfg_wdata_i;
        REG_DOUBLE_GAP:   dbl_gap_q     <= cfg_wdata_i;
        REG_DOUBLE_PAUSE: dbl_pause_q   <= cfg_wdata_i;
        REG_ALTERNATE:    alt_q         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance state on each accepted event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= PAT_OFF;
      lit_q       <= 1'b0;
      elapsed_q   <= '0;
      phase_q     <= PH_PULSE1;
      force_q     <= 1'b0;
      force_lvl_q <= 1'b0;
      timed_q     <= 1'b0;
      left_q      <= '0;
    end else if (evt_fire) begin
      pattern_q   <= pattern_d;
      lit_q       <= lit_d;
      elapsed_q   <= elapsed_d;
      phase_q     <= phase_d;
      force_q     <= force_d;
      force_lvl_q <= force_lvl_d;
      timed_q     <= timed_d;
      left_q      <= left_d;
    end
  end

  // Result register: hold until taken, refill on every accepted event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (evt_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      res_led_q <= lit_d;
      res_pin_q <= active_high_q ? lit_d : !lit_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.led_on    = res_led_q;
  assign res_o.pin_level = res_pin_q;

  // A timed flash is always a force.
  a_timed_implies_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timed_q |-> force_q)
    else $error("flash timer running without an active force");

  // Every accepted event leaves a result behind.
  a_event_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire |=> res_valid_q)
    else $error("accepted event produced no result");

  // Release drops any force.
  a_release_drops_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire && evt_i.mode == MODE_RELEASE |=> !force_q && !timed_q && left_q == '0)
    else $error("release left a force in place");

  // Elapsed time never wraps from its maximum.
  a_elapsed_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire && evt_i.mode == MODE_TICK && elapsed_q == TIME_MAX
    |=> elapsed_q == TIME_MAX || elapsed_q == '0)
    else $error("elapsed counter wrapped");

endmodule

[sim/status_led_pattern_controller_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pattern_controller_core_test: self-checking bench of the LED core
// Drives event words with random gaps and result stalls, predicts the LED
// state and pin level of every event, and compares each result word in order.
// ----------------------------------------------------------------------------
module status_led_pattern_controller_core_test;
  import slpc_pkg::*;

  localparam int HALF_PERIOD_NS = 6;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int HOLD_CYCLES    = 48;
  localparam int DISABLED_TICKS = 45;
  localparam int DRAIN_CYCLES   = 1_000;
  localparam int MAX_PRINTED    = 40;

  // Codes outside the defined sets; the block must ignore or pass them through.
  localparam logic [MODE_W-1:0]    MODE_BAD_A = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_BAD_B = 3'd7;
  localparam logic [PATTERN_W-1:0] PAT_BAD_A  = 3'd6;
  localparam logic [PATTERN_W-1:0] PAT_BAD_B  = 3'd7;

  localparam logic [DUR_W-1:0] TIME_MAX = '1;

  typedef enum int {
    CFG_SHORT,
    CFG_EXTREME,
    CFG_DISABLED,
    CFG_MIXED
  } cfg_flavor_e;

  typedef struct packed {
    logic led_on;
    logic pin_level;
  } led_word_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  slpc_evt_if evt ();
  slpc_res_if res ();

  status_led_pattern_controller_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt_i      (evt),
    .res_o      (res)
  );

  // Bench-side copy of the LED controller: registers and pattern state.
  logic             cfg_enabled;
  logic             cfg_active_high;
  logic [CFG_W-1:0] cfg_slow_half;
  logic [CFG_W-1:0] cfg_fast_half;
  logic [CFG_W-1:0] cfg_double_on;
  logic [CFG_W-1:0] cfg_double_gap;
  logic [CFG_W-1:0] cfg_double_pause;
  logic [CFG_W-1:0] cfg_alternate;

  pattern_e         cur_pattern;
  logic             led_lit;
  logic [DUR_W-1:0] elapsed_ms;
  dbl_phase_e       dbl_phase;
  logic             force_active;
  logic             force_level;
  logic             flash_timed;
  logic [DUR_W-1:0] flash_left_ms;

  // LED words still owed by the block, oldest first.
  led_word_t expected_leds[$];

  bit idle_on;
  bit hold_req;
  logic hold_on;

  int error_count;
  int events_sent;
  int ticks_sent;
  int odd_codes_sent;
  int cfg_writes;
  int results_checked;
  int evt_stall_cycles;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(HALF_PERIOD_NS) clk_i = ~clk_i;
  end

  // Stop a hung run; the limit sits far above the slowest passing run.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD_NS);
    $display("Timeout: run did not finish within %0d cycles", LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void reset_led_model();
    cfg_enabled      = 1'b1;
    cfg_active_high  = 1'b1;
    cfg_slow_half    = RST_SLOW_HALF;
    cfg_fast_half    = RST_FAST_HALF;
    cfg_double_on    = RST_DOUBLE_ON;
    cfg_double_gap   = RST_DOUBLE_GAP;
    cfg_double_pause = RST_DOUBLE_PAUSE;
    cfg_alternate    = RST_ALTERNATE;
    cur_pattern      = PAT_OFF;
    led_lit          = 1'b0;
    elapsed_ms       = '0;
    dbl_phase        = PH_PULSE1;
    force_active     = 1'b0;
    force_level      = 1'b0;
    flash_timed      = 1'b0;
    flash_left_ms    = '0;
  endfunction

  function automatic void release_force();
    force_active  = 1'b0;
    flash_timed   = 1'b0;
    flash_left_ms = '0;
  endfunction

  // Toggle the LED once the interval has run out, then restart the interval.
  function automatic void toggle_every(logic [CFG_W-1:0] interval);
    if (elapsed_ms >= interval) begin
      elapsed_ms = '0;
      led_lit    = ~led_lit;
    end
  endfunction

  // Hold the level of the current double-blink phase; advance when it expires.
  function automatic void double_step(logic [CFG_W-1:0] interval, logic level);
    led_lit = level;
    if (elapsed_ms >= interval) begin
      elapsed_ms = '0;
      dbl_phase  = dbl_phase_e'(dbl_phase + 2'd1);
    end
  endfunction

  function automatic led_word_t predict_led(logic [MODE_W-1:0] mode,
                                            logic [PATTERN_W-1:0] pat,
                                            logic [DUR_W-1:0] dur);
    led_word_t word;
    case (mode)
      MODE_TICK: begin
        // Time runs even while disabled; both counters saturate.
        if (elapsed_ms != TIME_MAX) elapsed_ms = elapsed_ms + 1'b1;
        if (flash_timed && flash_left_ms != '0) flash_left_ms = flash_left_ms - 1'b1;
        if (cfg_enabled) begin
          // An expired flash lets go first, so the pattern runs on this tick.
          if (force_active && flash_timed && flash_left_ms == '0) release_force();
          if (force_active) begin
            led_lit = force_level;
          end else begin
            case (cur_pattern)
              PAT_OFF:    led_lit = 1'b0;
              PAT_SOLID:  led_lit = 1'b1;
              PAT_SLOW:   toggle_every(cfg_slow_half);
              PAT_FAST:   toggle_every(cfg_fast_half);
              PAT_DOUBLE: begin
                case (dbl_phase)
                  PH_PULSE1: double_step(cfg_double_on, 1'b1);
                  PH_GAP:    double_step(cfg_double_gap, 1'b0);
                  PH_PULSE2: double_step(cfg_double_on, 1'b1);
                  default:   double_step(cfg_double_pause, 1'b0);
                endcase
              end
              PAT_ALT:    toggle_every(cfg_alternate);
              default:    ;
            endcase
          end
        end
      end
      MODE_SET: begin
        // Unknown codes and the pattern already running change nothing.
        if (pat <= PAT_ALT && pat != cur_pattern) begin
          cur_pattern = pattern_e'(pat);
          elapsed_ms  = '0;
          dbl_phase   = PH_PULSE1;
          release_force();
          led_lit     = (pat != PAT_OFF);
        end
      end
      MODE_FORCE_ON, MODE_FORCE_OFF: begin
        force_active  = 1'b1;
        force_level   = (mode == MODE_FORCE_ON);
        flash_timed   = 1'b0;
        flash_left_ms = '0;
        led_lit       = force_level;
      end
      MODE_RELEASE: release_force();
      MODE_FLASH: begin
        // Duration and countdown are equally wide, so no clamp is needed.
        force_active  = 1'b1;
        force_level   = 1'b1;
        flash_timed   = 1'b1;
        flash_left_ms = dur;
        led_lit       = 1'b1;
      end
      default: ;
    endcase
    word.led_on    = led_lit;
    word.pin_level = cfg_active_high ? led_lit : ~led_lit;
    return word;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Offer one event word, hold it until taken, then log its predicted LED word.
  // Valid stays up on return so back-to-back words need no extra edge.
  task automatic send_event(input logic [MODE_W-1:0] mode, input logic [PATTERN_W-1:0] pat,
                            input logic [DUR_W-1:0] dur);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid    <= 1'b1;
    evt.mode     <= mode;
    evt.pattern  <= pat;
    evt.flash_ms <= dur;
    do @(posedge clk_i); while (!evt.ready);
    expected_leds.push_back(predict_led(mode, pat, dur));
    events_sent++;
    if (mode == MODE_TICK) ticks_sent++;
    if (mode > MODE_FLASH) odd_codes_sent++;
  endtask

  // Write one register once the block has nothing left in flight.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    evt.valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk_i);
    // Let the result register settle.
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ENABLED:      cfg_enabled      = val[0];
      REG_ACTIVE_HIGH:  cfg_active_high  = val[0];
      REG_SLOW_HALF:    cfg_slow_half    = val;
      REG_FAST_HALF:    cfg_fast_half    = val;
      REG_DOUBLE_ON:    cfg_double_on    = val;
      REG_DOUBLE_GAP:   cfg_double_gap   = val;
      REG_DOUBLE_PAUSE: cfg_double_pause = val;
      default:          cfg_alternate    = val;
    endcase
    cfg_writes++;
  endtask

  // Result side: random stall bursts, plus the long hold.
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (hold_on === 1'b1) begin
        res.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Long hold of the result side, counted here so the sender keeps pushing.
  initial begin
    hold_on <= 1'b0;
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    led_word_t want;
    if (rst_ni === 1'b1) begin
      if (evt.valid === 1'b1 && evt.ready !== 1'b1) evt_stall_cycles++;
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        results_checked++;
        if (expected_leds.size() == 0) begin
          report_error("result word with no event waiting for it");
        end else begin
          want = expected_leds.pop_front();
          if (res.led_on !== want.led_on)
            report_error($sformatf("result %0d led_on: want %0b, got %0b",
                                   results_checked, want.led_on, res.led_on));
          if (res.pin_level !== want.pin_level)
            report_error($sformatf("result %0d pin_level: want %0b, got %0b",
                                   results_checked, want.pin_level, res.pin_level));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk every event kind, the odd codes and the force/flash corner cases.
  task automatic test_directed_events();
    idle_on = 1'b1;
    send_event(MODE_TICK, PAT_OFF, '0);             // off pattern stays dark
    send_event(MODE_BAD_A, PAT_BAD_B, '1);          // unknown mode: report only
    send_event(MODE_BAD_B, PAT_BAD_A, '0);
    send_event(MODE_SET, PAT_BAD_B, '1);            // unknown pattern ignored
    send_event(MODE_SET, PAT_OFF, '0);              // same pattern ignored
    send_event(MODE_SET, PAT_SOLID, '0);
    send_event(MODE_SET, PAT_SOLID, '0);
    send_event(MODE_FORCE_OFF, PAT_OFF, '0);
    send_event(MODE_TICK, PAT_OFF, '0);             // force wins over solid
    send_event(MODE_FORCE_ON, PAT_OFF, '0);
    send_event(MODE_RELEASE, PAT_OFF, '0);          // LED holds until next tick
    send_event(MODE_TICK, PAT_OFF, '0);
    send_event(MODE_FLASH, PAT_OFF, '0);
    send_event(MODE_SET, PAT_OFF, '0);              // pattern change drops flash
    send_event(MODE_FLASH, PAT_OFF, '0);            // zero-length flash
    send_event(MODE_TICK, PAT_OFF, '0);             // ...lets go on this tick
    send_event(MODE_FLASH, PAT_OFF, '1);
    send_event(MODE_TICK, PAT_BAD_B, '1);
    send_event(MODE_RELEASE, PAT_OFF, '0);
    send_event(MODE_SET, PAT_SLOW, '0);
    send_event(MODE_SET, PAT_FAST, '0);
    send_event(MODE_SET, PAT_DOUBLE, '0);
    send_event(MODE_SET, PAT_ALT, '0);
  endtask

  // A zero interval fires the blink step on every tick.
  task automatic test_interval_zero();
    write_reg(REG_SLOW_HALF, '0);
    send_event(MODE_SET, PAT_SLOW, '0);
    repeat (3) send_event(MODE_TICK, PAT_OFF, '0);
    write_reg(REG_SLOW_HALF, RST_SLOW_HALF);
  endtask

  // Program a register set, then mostly ticks between random pattern changes,
  // forces and flashes, with odd codes mixed in as noise.
  task automatic test_random_events(input int n_events, input bit with_idle,
                                    input cfg_flavor_e flavor);
    logic [MODE_W-1:0]    mode;
    logic [PATTERN_W-1:0] pat;
    logic [DUR_W-1:0]     dur;
    int                   pick;
    logic [CFG_W-1:0]     interval;
    idle_on = with_idle;
    write_reg(REG_ENABLED, (flavor == CFG_DISABLED) ? '0 : 16'd1);
    case (flavor)
      CFG_SHORT:   write_reg(REG_ACTIVE_HIGH, 16'd1);
      CFG_EXTREME: write_reg(REG_ACTIVE_HIGH, '0);
      default:     write_reg(REG_ACTIVE_HIGH, CFG_W'($urandom_range(0, 1)));
    endcase
    for (int i = REG_SLOW_HALF; i <= REG_ALTERNATE; i++) begin
      case (flavor)
        CFG_SHORT:    interval = CFG_W'($urandom_range(1, 4));
        CFG_EXTREME:  interval = ($urandom_range(0, 2) == 0) ? '1 : 16'd1;
        CFG_DISABLED: interval = CFG_W'($urandom_range(1, 3));
        default:      interval = CFG_W'($urandom_range(1, 12));
      endcase
      write_reg(reg_idx_e'(i), interval);
    end
    repeat (n_events) begin
      pick = $urandom_range(0, 99);
      pat  = PATTERN_W'($urandom);
      dur  = DUR_W'($urandom);
      if (pick < 55) begin
        mode = MODE_TICK;
      end else if (pick < 67) begin
        mode = MODE_SET;
        if ($urandom_range(0, 9) != 0) pat = PATTERN_W'($urandom_range(PAT_OFF, PAT_ALT));
      end else if (pick < 73) begin
        mode = MODE_FORCE_ON;
      end else if (pick < 78) begin
        mode = MODE_FORCE_OFF;
      end else if (pick < 84) begin
        mode = MODE_RELEASE;
      end else if (pick < 93) begin
        // Mostly short flashes so they expire within the stream.
        mode = MODE_FLASH;
        if ($urandom_range(0, 3) != 0) dur = DUR_W'($urandom_range(0, 6));
      end else begin
        mode = $urandom_range(0, 1) ? MODE_BAD_A : MODE_BAD_B;
      end
      send_event(mode, pat, dur);
    end
  endtask

  // Stall the result side for a long stretch while events keep coming, so the
  // result register fills and the event input must back off.
  task automatic test_result_backpressure();
    idle_on = 1'b0;
    write_reg(REG_ENABLED, 16'd1);
    write_reg(REG_FAST_HALF, 16'd2);
    send_event(MODE_SET, PAT_FAST, '0);
    hold_req = 1'b1;
    repeat (30) send_event(MODE_TICK, PATTERN_W'($urandom), DUR_W'($urandom));
    wait (!hold_req);
  endtask

  // Let a flash run out while disabled, then re-enable: the flash lets go on
  // the first enabled tick and the overdue slow blink fires at once.
  task automatic test_disabled_time();
    idle_on = 1'b0;
    write_reg(REG_ENABLED, 16'd1);
    write_reg(REG_ACTIVE_HIGH, '0);
    write_reg(REG_SLOW_HALF, 16'd40);
    send_event(MODE_SET, PAT_OFF, '0);
    send_event(MODE_SET, PAT_SLOW, '0);
    send_event(MODE_FLASH, PAT_OFF, 16'd30);
    write_reg(REG_ENABLED, '0);
    repeat (DISABLED_TICKS) send_event(MODE_TICK, PAT_OFF, '0);
    write_reg(REG_ENABLED, 16'd1);
    repeat (3) send_event(MODE_TICK, PAT_OFF, '0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int drain_cycles;
    error_count      = 0;
    events_sent      = 0;
    ticks_sent       = 0;
    odd_codes_sent   = 0;
    cfg_writes       = 0;
    results_checked  = 0;
    evt_stall_cycles = 0;
    idle_on          = 1'b0;
    hold_req         = 1'b0;
    reset_led_model();

    // Hold every input at a known value through reset.
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_ENABLED;
    cfg_wdata_i  <= '0;
    evt.valid    <= 1'b0;
    evt.mode     <= MODE_TICK;
    evt.pattern  <= PAT_OFF;
    evt.flash_ms <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_events();
    test_interval_zero();
    test_random_events(200, 1'b1, CFG_SHORT);
    test_random_events(150, 1'b1, CFG_EXTREME);
    test_random_events(100, 1'b0, CFG_DISABLED);
    test_random_events(200, 1'b1, CFG_MIXED);
    test_result_backpressure();
    test_disabled_time();

    // Drop valid and let the last results come home.
    evt.valid <= 1'b0;
    drain_cycles = 0;
    while (expected_leds.size() != 0 && drain_cycles < DRAIN_CYCLES) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (expected_leds.size() != 0)
      report_error($sformatf("%0d LED words never arrived", expected_leds.size()));
    repeat (4) @(posedge clk_i);

    $display("Checked %0d LED words from %0d events (%0d ticks, %0d odd codes), %0d reg writes",
             results_checked, events_sent, ticks_sent, odd_codes_sent, cfg_writes);
    $display("All six patterns, force, flash, polarity and disabled time run; %0d input stalls",
             evt_stall_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
